### rtl/core/bdhd_pkg.sv
// Package for the button debounce and hold detect unit.
// Holds register widths, register addresses and the result bundle type.
// No dependencies.
package bdhd_pkg;

    localparam int HOLD_COUNT_WIDTH = 16;
    localparam int DEB_W            = 4;
    localparam int HOLD_W           = 16;
    localparam int CMP_W            = (HOLD_COUNT_WIDTH > HOLD_W) ? HOLD_COUNT_WIDTH : HOLD_W;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [DEB_W-1:0]            DEB_RESET  = DEB_W'(6);
    localparam logic [HOLD_W-1:0]           HOLD_RESET = HOLD_W'(200);
    localparam logic [HOLD_COUNT_WIDTH-1:0] TIMER_MAX  = '1;

    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_HOLD     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic short_press;
        logic long_hold;
        logic debounced_level;
    } result_t;

endpackage

### rtl/core/button_debounce_hold_detect_unit.sv
// Top level of the button debounce and hold detect unit.
// Depends on bdhd_pkg for widths, register addresses and the result bundle.
//
// Usage:
//   s_ channel: one raw button sample per request (s_raw_pressed, 1 = pressed).
//   m_ channel: exactly one result per sample: short_press and long_hold pulses
//   plus the debounced level after that sample.
//   APB port: register 0 at 0x0 is debounce_ticks (4 bits), register 1 at 0x4
//   is hold_ticks (16 bits). Reads return the current values; pready is tied
//   high. Write registers only while the block holds no pending request.
// Output: each result is registered, into the skid register if the result
//   register is still held. Throughput: one sample per cycle while s_ready is
//   high. The debounce and hold state is updated at the accept edge by one pass
//   of counter/compare logic into the result or skid register.
// Stall: a two-entry output buffer (result register plus skid register) lets
//   one more sample in after m_ready drops; s_ready falls once the skid
//   register is occupied.
// Reset: aresetn (synchronous, active low) sets the level to released, clears
//   the counters and both buffers, and restores the register defaults.
module button_debounce_hold_detect_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdhd_pkg::PADDR_W-1:0]  paddr,
    input  logic [bdhd_pkg::PDATA_W-1:0]  pwdata,
    output logic [bdhd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_raw_pressed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_short_press,
    output logic                          m_long_hold,
    output logic                          m_debounced_level
);
    import bdhd_pkg::*;

    logic [DEB_W-1:0]            debounce_ticks_reg;
    logic [HOLD_W-1:0]           hold_ticks_reg;
    logic                        stable_level_reg, stable_level_next;
    logic                        cand_level_reg, cand_level_next;
    logic [DEB_W-1:0]            cand_count_reg, cand_count_next;
    logic [HOLD_COUNT_WIDTH-1:0] press_timer_reg, press_timer_next;
    logic                        hold_reported_reg, hold_reported_next;
    result_t                     result_next;
    result_t                     out_reg, skid_reg;
    logic                        out_valid_reg, skid_valid_reg;
    logic                        push, pop, cfg_wr;
    reg_idx_t                    cfg_idx;
    logic                        hr_mid;
    logic [HOLD_COUNT_WIDTH-1:0] timer_mid, timer_inc;

    // APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_DEBOUNCE: prdata = PDATA_W'(debounce_ticks_reg);
            REG_HOLD:     prdata = PDATA_W'(hold_ticks_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEB_RESET;
            hold_ticks_reg     <= HOLD_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEBOUNCE: debounce_ticks_reg <= pwdata[DEB_W-1:0];
                REG_HOLD:     hold_ticks_reg     <= pwdata[HOLD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Debounce and hold detection, one sample per pass
    always_comb begin
        stable_level_next  = stable_level_reg;
        cand_level_next    = cand_level_reg;
        cand_count_next    = cand_count_reg;
        press_timer_next   = press_timer_reg;
        hold_reported_next = hold_reported_reg;
        result_next        = '0;
        timer_mid          = press_timer_reg;
        hr_mid             = hold_reported_reg;
        timer_inc          = '0;

        if (s_raw_pressed != cand_level_reg) begin
            cand_level_next = s_raw_pressed;
            cand_count_next = DEB_W'(1);
        end else if (cand_count_reg < debounce_ticks_reg) begin
            cand_count_next = cand_count_reg + DEB_W'(1);
        end else begin
            stable_level_next = cand_level_reg;
            if (stable_level_reg != cand_level_reg) begin
                if (cand_level_reg) begin
                    timer_mid = '0;
                    hr_mid    = 1'b0;
                end else if (!hold_reported_reg) begin
                    result_next.short_press = 1'b1;
                end
            end
            if (cand_level_reg && !hr_mid) begin
                timer_inc = (timer_mid == TIMER_MAX) ? timer_mid
                                                     : timer_mid + HOLD_COUNT_WIDTH'(1);
                timer_mid = timer_inc;
                if (CMP_W'(timer_inc) >= CMP_W'(hold_ticks_reg)) begin
                    hr_mid                = 1'b1;
                    result_next.long_hold = 1'b1;
                end
            end
            press_timer_next   = timer_mid;
            hold_reported_next = hr_mid;
        end
        result_next.debounced_level = stable_level_next;
    end

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_level_reg  <= 1'b0;
            cand_level_reg    <= 1'b0;
            cand_count_reg    <= '0;
            press_timer_reg   <= '0;
            hold_reported_reg <= 1'b0;
        end else if (push) begin
            stable_level_reg  <= stable_level_next;
            cand_level_reg    <= cand_level_next;
            cand_count_reg    <= cand_count_next;
            press_timer_reg   <= press_timer_next;
            hold_reported_reg <= hold_reported_next;
        end
    end

    // Result register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= result_next;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= result_next;
            end else begin
                out_reg <= result_next;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_short_press     = out_reg.short_press;
    assign m_long_hold       = out_reg.long_hold;
    assign m_debounced_level = out_reg.debounced_level;

    // Assertions
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_hold_when_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_long_hold |-> m_debounced_level)
        else $error("long_hold reported while released");

    a_short_when_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_short_press |-> !m_debounced_level && !m_long_hold)
        else $error("short_press reported while pressed or with long_hold");

    // a new stable press restarts the timer even when the hold fires again at once
    a_timer_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reported_reg && $past(hold_reported_reg) && !$rose(stable_level_reg)
        |-> $stable(press_timer_reg))
        else $error("hold timer moved after the hold was reported");

endmodule
